@@ sv/ehc_pkg.sv @@
// Shared constants, codes and types of the Ethernet/IP/L4 header classifier.
`timescale 1ns / 1ps
`default_nettype none

package ehc_pkg;

   // Frame length counter saturates at MAX_FRAME_BYTES, so it must hold that value.
   localparam int MAX_FRAME_BYTES = 16384;
   localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SIZE_W          = 14;
   localparam int OFF_W           = 8;
   localparam int HDR_W           = 6;
   localparam int BYTE_W          = 8;
   localparam int ETYPE_W         = 16;
   localparam int RSP_W           = 32;

   // EtherTypes and IP protocol numbers
   localparam logic [ETYPE_W-1:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [ETYPE_W-1:0] ETYPE_IPV6   = 16'h86DD;
   localparam logic [BYTE_W-1:0]  PROTO_ICMP   = 8'd1;
   localparam logic [BYTE_W-1:0]  PROTO_TCP    = 8'd6;
   localparam logic [BYTE_W-1:0]  PROTO_UDP    = 8'd17;
   localparam logic [BYTE_W-1:0]  PROTO_ICMPV6 = 8'd58;

   // Byte positions within the frame
   localparam logic [IDX_W-1:0] POS_ETYPE_HI  = IDX_W'(12);
   localparam logic [IDX_W-1:0] POS_ETYPE_LO  = IDX_W'(13);
   localparam logic [IDX_W-1:0] POS_IHL       = IDX_W'(14);
   localparam logic [IDX_W-1:0] POS_V4_PROTO  = IDX_W'(23);
   localparam logic [IDX_W-1:0] POS_V6_PROTO  = IDX_W'(20);
   localparam logic [IDX_W-1:0] POS_V4_DOFF   = IDX_W'(26);
   localparam logic [IDX_W-1:0] POS_V6_DOFF   = IDX_W'(66);

   // Header lengths
   localparam logic [OFF_W-1:0] ETH_HDR       = OFF_W'(14);
   localparam logic [OFF_W-1:0] IP6_HDR       = OFF_W'(40);
   localparam logic [OFF_W-1:0] SMALL_L4_HDR  = OFF_W'(8);
   localparam logic [OFF_W-1:0] TCP_DOFF_REL  = OFF_W'(12);
   localparam logic [SIZE_W-1:0] SIZE_MAX     = {SIZE_W{1'b1}};

   typedef enum logic [1:0] {
      NET_OTHER = 2'd0,
      NET_IPV4  = 2'd1,
      NET_IPV6  = 2'd2,
      NET_EXTRA = 2'd3
   } net_kind_type;

   typedef enum logic [2:0] {
      TRANSPORT_NONE   = 3'd0,
      TRANSPORT_TCP    = 3'd1,
      TRANSPORT_UDP    = 3'd2,
      TRANSPORT_ICMP   = 3'd3,
      TRANSPORT_ICMPV6 = 3'd4
   } transport_kind_type;

   // Per-frame captured state
   typedef struct packed {
      logic [IDX_W-1:0]   byte_index;
      logic [ETYPE_W-1:0] ether_type_seen;
      logic [HDR_W-1:0]   ip_header_bytes;
      logic [BYTE_W-1:0]  next_protocol;
      logic [HDR_W-1:0]   tcp_header_bytes;
   } frame_state_type;

   // Result item, last field in the lowest bits
   typedef struct packed {
      logic [RSP_W-SIZE_W-OFF_W-7:0] pad;
      logic                          headers_truncated;
      logic [SIZE_W-1:0]             payload_size;
      logic [OFF_W-1:0]              payload_offset;
      transport_kind_type            transport_kind;
      net_kind_type                  net_kind;
   } result_type;

endpackage

`default_nettype wire

@@ sv/ethernet_ip_l4_header_classifier_unit.sv @@
// A last byte passes the byte input register, then the result register.
// Throughput: one frame byte per cycle; the byte stage holds only while a
//   last byte waits behind an untaken result.
// The byte input register and the result register bracket one level of capture
//   and classification logic.
// Reset (synchronous, active high) clears frame state, the valid flags of both
//   stages and the extra EtherType register to 0.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_ip_l4_header_classifier_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire logic        req_tlast,   // frame_end
   output wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output wire logic [31:0] rsp_tdata,   // [1:0] net_kind, [4:2] transport_kind,
                                         // [12:5] payload_offset, [26:13] payload_size,
                                         // [27] headers_truncated, [31:28] zero
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata    // extra_ether_type
);
   import ehc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;
   logic [ETYPE_W-1:0] cfg_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;
   result_type         result;
   frame_state_type    upd;
   logic               advance;
   logic               accept;
   logic               rsp_load;

   // A byte moves on unless it is a last byte facing a stalled result
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = advance && in_last_ff;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   ehc_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .frame_byte (in_byte_ff),
      .frame_end  (in_last_ff),
      .upd        (upd)
   );

   ehc_classify u_classify (
      .st               (upd),
      .extra_ether_type (cfg_ff),
      .result           (result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cfg_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/ehc_capture.sv @@
// Frame byte counter and header field capture for the header classifier.
`timescale 1ns / 1ps
`default_nettype none

module ehc_capture (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic [7:0]              frame_byte,
   input  wire logic                    frame_end,
   output ehc_pkg::frame_state_type     upd
);
   import ehc_pkg::*;

   frame_state_type state_ff;
   frame_state_type state_in;
   logic [IDX_W-1:0] pos;
   logic             pos_ok;
   logic             v4_body;
   logic             v6_body;

   assign pos     = state_ff.byte_index;
   assign pos_ok  = (pos < IDX_W'(MAX_FRAME_BYTES));
   assign v4_body = (state_ff.ether_type_seen == ETYPE_IPV4) && (pos >= POS_IHL);
   assign v6_body = (state_ff.ether_type_seen == ETYPE_IPV6) && (pos >= POS_IHL);

   // Apply this byte to the captured fields; the count holds once saturated
   always_comb begin
      upd = state_ff;
      if (pos_ok) begin
         if (pos == POS_ETYPE_HI) begin
            upd.ether_type_seen[15:8] = frame_byte;
         end
         if (pos == POS_ETYPE_LO) begin
            upd.ether_type_seen[7:0] = frame_byte;
         end
         if (pos == POS_IHL) begin
            upd.ip_header_bytes = {frame_byte[3:0], 2'b00};
         end
         if (v4_body) begin
            if (pos == POS_V4_PROTO) begin
               upd.next_protocol = frame_byte;
            end
            if (pos == POS_V4_DOFF + IDX_W'(state_ff.ip_header_bytes)) begin
               upd.tcp_header_bytes = {frame_byte[7:4], 2'b00};
            end
         end
         if (v6_body) begin
            if (pos == POS_V6_PROTO) begin
               upd.next_protocol = frame_byte;
            end
            if (pos == POS_V6_DOFF) begin
               upd.tcp_header_bytes = {frame_byte[7:4], 2'b00};
            end
         end
         upd.byte_index = pos + IDX_W'(1);
      end
   end

   // Advance on each byte; clear after the last byte of a frame
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = frame_end ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ehc_classify.sv @@
// Frame classification from captured header fields at the end of a frame.
`timescale 1ns / 1ps
`default_nettype none

module ehc_classify (
   input  wire ehc_pkg::frame_state_type  st,
   input  wire logic [15:0]               extra_ether_type,
   output ehc_pkg::result_type            result
);
   import ehc_pkg::*;

   logic [IDX_W-1:0]  len;
   logic              is_ip;
   logic [OFF_W-1:0]  netend;
   logic [IDX_W-1:0]  protopos;
   logic [OFF_W-1:0]  hend;
   logic              known;
   logic              trunc;

   // Payload size for a header end at or below len, clipped to the field range
   function automatic logic [SIZE_W-1:0] sat_size(input logic [IDX_W-1:0] n,
                                                  input logic [OFF_W-1:0] hdr);
      logic [IDX_W-1:0] diff;
      diff = n - IDX_W'(hdr);
      if (diff > IDX_W'(SIZE_MAX)) begin
         return SIZE_MAX;
      end
      return diff[SIZE_W-1:0];
   endfunction

   assign len = st.byte_index;

   always_comb begin
      result   = '0;
      is_ip    = 1'b0;
      netend   = '0;
      protopos = '0;
      hend     = '0;
      known    = 1'b0;
      trunc    = 1'b0;

      // Network layer: IPv4 and IPv6 win over an equal extra EtherType
      priority if (len < IDX_W'(ETH_HDR)) begin
         trunc = 1'b1;
      end else if (st.ether_type_seen == ETYPE_IPV4) begin
         result.net_kind = NET_IPV4;
         is_ip    = 1'b1;
         netend   = ETH_HDR + OFF_W'(st.ip_header_bytes);
         protopos = POS_V4_PROTO;
      end else if (st.ether_type_seen == ETYPE_IPV6) begin
         result.net_kind = NET_IPV6;
         is_ip    = 1'b1;
         netend   = ETH_HDR + IP6_HDR;
         protopos = POS_V6_PROTO;
      end else if (st.ether_type_seen == extra_ether_type) begin
         result.net_kind       = NET_EXTRA;
         result.payload_offset = ETH_HDR;
         result.payload_size   = sat_size(len, ETH_HDR);
      end else begin
         result.net_kind = NET_OTHER;
      end

      // Transport layer under IP
      if (is_ip) begin
         if (len <= protopos) begin
            trunc = 1'b1;
         end else begin
            priority if (st.next_protocol == PROTO_TCP) begin
               result.transport_kind = TRANSPORT_TCP;
               known = 1'b1;
               hend  = netend + OFF_W'(st.tcp_header_bytes);
               if (len <= IDX_W'(netend + TCP_DOFF_REL)) begin
                  trunc = 1'b1;
               end
            end else if (st.next_protocol == PROTO_UDP) begin
               result.transport_kind = TRANSPORT_UDP;
               known = 1'b1;
               hend  = netend + SMALL_L4_HDR;
            end else if (st.next_protocol == PROTO_ICMP &&
                         result.net_kind == NET_IPV4) begin
               result.transport_kind = TRANSPORT_ICMP;
               known = 1'b1;
               hend  = netend + SMALL_L4_HDR;
            end else if (st.next_protocol == PROTO_ICMPV6 &&
                         result.net_kind == NET_IPV6) begin
               result.transport_kind = TRANSPORT_ICMPV6;
               known = 1'b1;
               hend  = netend + SMALL_L4_HDR;
            end else begin
               if (len < IDX_W'(netend)) begin
                  trunc = 1'b1;
               end
            end
            if (known) begin
               result.payload_offset = hend;
               if (len < IDX_W'(hend)) begin
                  trunc = 1'b1;
               end
               if (!trunc) begin
                  result.payload_size = sat_size(len, hend);
               end
            end
         end
      end

      result.headers_truncated = trunc;
   end

endmodule

`default_nettype wire

@@ sv/ehc_checker.sv @@
// Port-level checks of the header classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ehc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A new result follows a last-byte transfer on the request port
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last-byte transfer");

   // Input backpressure only comes from a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

endmodule

bind ethernet_ip_l4_header_classifier_unit ehc_checker u_ehc_checker (.*);

`default_nettype wire
